>>> sv/qtg_pkg.sv
// Shared types, constants and helper functions for the quintic trajectory generator.
// No dependencies; qtg_alu, qtg_core, the top level and the testbench import this package.
`default_nettype none

package qtg_pkg;

  // Width of the shared add/subtract datapath and of all wide operands.
  localparam int unsigned AluWidth = 88;
  // Quotient bits produced by one division; larger quotients flag overflow.
  localparam int unsigned QuoBits = 34;
  // Width of the multiplier operand that is scanned bit by bit.
  localparam int unsigned MulYWidth = 32;

  localparam logic [5:0] SegResetValue = 6'd20;
  localparam int unsigned DefMaxSegments = 63;
  localparam int unsigned DefPosFracBits = 24;

  localparam logic [31:0] SatPos = 32'h7FFF_FFFF;
  localparam logic [31:0] SatNeg = 32'h8000_0000;

  typedef enum logic {
    ALU_MUL = 1'b0,
    ALU_DIV = 1'b1
  } alu_op_e;

  typedef struct packed {
    logic                start;
    alu_op_e             op;
    logic [AluWidth-1:0] a;
    logic [AluWidth-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic                done;
    logic                ovf;
    logic [AluWidth-1:0] res;
  } alu_rsp_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] position;
    logic [31:0] velocity;
    logic [31:0] acceleration;
    logic [31:0] time_ms;
    logic [5:0]  number;
    logic        last_point;
    logic        end_of_plan;
  } point_t;

  // Apply the sign to a rounded magnitude and saturate it to 32 bits.
  function automatic logic [31:0] sat_signed(input logic neg, input logic ovf,
                                             input logic [QuoBits-1:0] q);
    logic [31:0] r;
    if (ovf) begin
      r = neg ? SatNeg : SatPos;
    end else if (neg) begin
      r = (q > QuoBits'(SatNeg)) ? SatNeg : (32'd0 - q[31:0]);
    end else begin
      r = (q > QuoBits'(SatPos)) ? SatPos : q[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> sv/qtg_alu.sv
// Shared iterative arithmetic unit: shift-add multiplier and restoring divider
// built around one wide adder. Depends on qtg_pkg.
`default_nettype none

module qtg_alu import qtg_pkg::*; (
  input  wire      clk_i,
  input  wire      rst_ni,
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  logic                 busy_q;
  logic                 div_q;
  logic                 chk_q;
  logic                 done_q;
  logic                 ovf_q;
  logic [AluWidth-1:0]  acc_q;
  logic [AluWidth-1:0]  x_q;
  logic [MulYWidth-1:0] y_q;
  logic [QuoBits-1:0]   nlo_q;
  logic [QuoBits-1:0]   quo_q;
  logic [5:0]           cnt_q;

  logic [AluWidth-1:0]  shifted;
  logic [AluWidth-1:0]  add_a;
  logic [AluWidth-1:0]  add_b;
  logic [AluWidth:0]    sum;
  logic                 ge;

  // One adder serves both operations; for division it subtracts and its carry
  // tells whether the partial remainder reaches the divisor.
  always_comb begin
    shifted = {acc_q[AluWidth-2:0], nlo_q[QuoBits-1]};
    add_a   = (div_q && !chk_q) ? shifted : acc_q;
    add_b   = div_q ? ~x_q : x_q;
    sum     = {1'b0, add_a} + {1'b0, add_b} + {{AluWidth{1'b0}}, div_q};
    ge      = sum[AluWidth];
  end

  // Operation sequencing.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      div_q  <= 1'b0;
      chk_q  <= 1'b0;
      done_q <= 1'b0;
      ovf_q  <= 1'b0;
      acc_q  <= '0;
      x_q    <= '0;
      y_q    <= '0;
      nlo_q  <= '0;
      quo_q  <= '0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (!busy_q) begin
        if (req_i.start) begin
          busy_q <= 1'b1;
          div_q  <= (req_i.op == ALU_DIV);
          chk_q  <= 1'b1;
          ovf_q  <= 1'b0;
          quo_q  <= '0;
          cnt_q  <= '0;
          x_q    <= req_i.op == ALU_DIV ? req_i.b : req_i.a;
          if (req_i.op == ALU_DIV) begin
            acc_q <= req_i.a >> QuoBits;
            nlo_q <= req_i.a[QuoBits-1:0];
          end else begin
            acc_q <= '0;
            y_q   <= req_i.b[MulYWidth-1:0];
          end
        end
      end else if (!div_q) begin
        // Multiply: add the shifted multiplicand for each set bit of y.
        if (y_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          if (y_q[0]) begin
            acc_q <= sum[AluWidth-1:0];
          end
          x_q <= x_q << 1;
          y_q <= y_q >> 1;
        end
      end else if (chk_q) begin
        // The quotient does not fit when the top part already reaches the divisor.
        if (ge) begin
          ovf_q  <= 1'b1;
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          chk_q <= 1'b0;
        end
      end else begin
        // One quotient bit per cycle.
        acc_q <= ge ? sum[AluWidth-1:0] : shifted;
        quo_q <= {quo_q[QuoBits-2:0], ge};
        nlo_q <= nlo_q << 1;
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'(QuoBits - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.ovf  = ovf_q;
  assign rsp_o.res  = div_q ? AluWidth'(quo_q) : acc_q;

endmodule

`default_nettype wire

>>> sv/qtg_core.sv
// Sequencer and operand registers that evaluate one joint's trajectory points
// on the shared unit. Depends on qtg_pkg and qtg_alu.
`default_nettype none

module qtg_core import qtg_pkg::*; #(
  parameter int unsigned MAX_SEGMENTS       = DefMaxSegments,
  parameter int unsigned POSITION_FRAC_BITS = DefPosFracBits
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire  [5:0]  seg_i,
  input  wire         item_i,
  input  wire  [31:0] start_position_i,
  input  wire  [31:0] end_position_i,
  input  wire  [23:0] duration_ms_i,
  input  wire  [30:0] start_time_ms_i,
  input  wire         last_joint_i,
  input  wire         out_free_i,
  output logic        idle_o,
  output point_t      point_o
);

  localparam int unsigned Lsh = POSITION_FRAC_BITS < 16 ? 16 - POSITION_FRAC_BITS : 0;
  localparam int unsigned Rsh = POSITION_FRAC_BITS > 16 ? POSITION_FRAC_BITS - 16 : 0;
  localparam logic [5:0]  MaxSeg = 6'(MAX_SEGMENTS);

  typedef enum logic [21:0] {
    S_IDLE = 22'h000001,
    S_N3   = 22'h000002,
    S_N4   = 22'h000004,
    S_N5   = 22'h000008,
    S_VDEN = 22'h000010,
    S_TAD  = 22'h000020,
    S_ADEN = 22'h000040,
    S_K3   = 22'h000080,
    S_PQ   = 22'h000100,
    S_PA   = 22'h000200,
    S_PDIV = 22'h000400,
    S_KK2  = 22'h000800,
    S_V2   = 22'h001000,
    S_V3   = 22'h002000,
    S_VDIV = 22'h004000,
    S_A1   = 22'h008000,
    S_A2   = 22'h010000,
    S_A3   = 22'h020000,
    S_ADIV = 22'h040000,
    S_TM   = 22'h080000,
    S_TDIV = 22'h100000,
    S_EMIT = 22'h200000
  } state_e;

  state_e              state_q;
  logic                issued_q;
  logic [5:0]          n_q;
  logic [5:0]          k_q;
  logic [31:0]         start_q;
  logic [32:0]         mag_q;
  logic                neg_q;
  logic [23:0]         dur_q;
  logic [23:0]         drate_q;
  logic [30:0]         toff_q;
  logic                lastj_q;
  logic [17:0]         n3_q;
  logic [23:0]         n4_q;
  logic [29:0]         n5_q;
  logic [AluWidth-1:0] vden_q;
  logic [AluWidth-1:0] aden_q;
  logic [AluWidth-1:0] tmp_q;
  logic [31:0]         pos_q;
  logic [31:0]         vel_q;
  logic [31:0]         accel_q;
  logic [31:0]         time_q;

  logic [11:0]         n2;
  logic [11:0]         k2;
  logic [11:0]         kn;
  logic [5:0]          nk;
  logic [11:0]         kk;
  logic [17:0]         inner;
  logic signed [7:0]   n2k;
  logic                n2k_neg;
  logic [6:0]          abs_n2k;
  logic [24:0]         vpoly;
  logic [21:0]         amag;
  logic signed [32:0]  dq;
  logic [5:0]          seg_eff;
  alu_req_t            req;
  alu_rsp_t            rsp;

  // Small per-point terms from the point index and the segment count.
  always_comb begin
    n2      = 12'(n_q) * 12'(n_q);
    k2      = 12'(k_q) * 12'(k_q);
    kn      = 12'(k_q) * 12'(n_q);
    nk      = n_q - k_q;
    kk      = 12'(k_q) * 12'(nk);
    inner   = 18'(n2) * 18'd10 + 18'(k2) * 18'd6 - 18'(kn) * 18'd15;
    n2k     = $signed({2'b00, n_q}) - $signed({1'b0, k_q, 1'b0});
    n2k_neg = n2k[7];
    abs_n2k = n2k_neg ? 7'(-n2k) : n2k[6:0];
    vpoly   = 25'(tmp_q[19:0]) * 25'd30;
    amag    = 22'(tmp_q[15:0]) * 22'd60;
    dq      = $signed({end_position_i[31], end_position_i})
            - $signed({start_position_i[31], start_position_i});
    if (seg_i == 6'd0) begin
      seg_eff = 6'd1;
    end else if (seg_i > MaxSeg) begin
      seg_eff = MaxSeg;
    end else begin
      seg_eff = seg_i;
    end
  end

  // Operands for the shared unit in each step.
  always_comb begin
    req.start = !issued_q && (state_q != S_IDLE) && (state_q != S_EMIT);
    req.op    = ALU_MUL;
    req.a     = '0;
    req.b     = '0;
    case (state_q)
      S_N3: begin
        req.a = AluWidth'(n2);
        req.b = AluWidth'(n_q);
      end
      S_N4: begin
        req.a = AluWidth'(n3_q);
        req.b = AluWidth'(n_q);
      end
      S_N5: begin
        req.a = AluWidth'(n4_q);
        req.b = AluWidth'(n_q);
      end
      S_VDEN: begin
        req.a = AluWidth'(n4_q);
        req.b = AluWidth'(drate_q);
      end
      S_TAD: begin
        req.a = AluWidth'(n3_q);
        req.b = AluWidth'(drate_q);
      end
      S_ADEN: begin
        req.a = tmp_q;
        req.b = AluWidth'(drate_q);
      end
      S_K3: begin
        req.a = AluWidth'(k2);
        req.b = AluWidth'(k_q);
      end
      S_PQ: begin
        req.a = tmp_q;
        req.b = AluWidth'(inner);
      end
      S_PA: begin
        req.a = AluWidth'(mag_q);
        req.b = tmp_q;
      end
      S_PDIV: begin
        req.op = ALU_DIV;
        req.a  = (tmp_q << 1) + AluWidth'(n5_q);
        req.b  = AluWidth'(n5_q) << 1;
      end
      S_KK2: begin
        req.a = AluWidth'(kk);
        req.b = AluWidth'(kk);
      end
      S_V2: begin
        req.a = AluWidth'(mag_q);
        req.b = AluWidth'(vpoly);
      end
      S_V3: begin
        req.a = tmp_q;
        req.b = AluWidth'(1000);
      end
      S_VDIV: begin
        req.op = ALU_DIV;
        req.a  = (tmp_q << (Lsh + 1)) + vden_q;
        req.b  = vden_q << 1;
      end
      S_A1: begin
        req.a = AluWidth'(kk);
        req.b = AluWidth'(abs_n2k);
      end
      S_A2: begin
        req.a = AluWidth'(mag_q);
        req.b = AluWidth'(amag);
      end
      S_A3: begin
        req.a = tmp_q;
        req.b = AluWidth'(1000000);
      end
      S_ADIV: begin
        req.op = ALU_DIV;
        req.a  = (tmp_q << (Lsh + 1)) + aden_q;
        req.b  = aden_q << 1;
      end
      S_TM: begin
        req.a = AluWidth'(dur_q);
        req.b = AluWidth'(k_q);
      end
      S_TDIV: begin
        req.op = ALU_DIV;
        req.a  = tmp_q;
        req.b  = AluWidth'(n_q);
      end
      default: begin
        req.op = ALU_MUL;
      end
    endcase
  end

  qtg_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  // Step sequencer: capture each result and move on to the next step.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      issued_q <= 1'b0;
      n_q      <= 6'd1;
      k_q      <= '0;
      start_q  <= '0;
      mag_q    <= '0;
      neg_q    <= 1'b0;
      dur_q    <= '0;
      drate_q  <= '0;
      toff_q   <= '0;
      lastj_q  <= 1'b0;
      n3_q     <= '0;
      n4_q     <= '0;
      n5_q     <= '0;
      vden_q   <= '0;
      aden_q   <= '0;
      tmp_q    <= '0;
      pos_q    <= '0;
      vel_q    <= '0;
      accel_q  <= '0;
      time_q   <= '0;
    end else if (state_q == S_IDLE) begin
      if (item_i) begin
        start_q  <= start_position_i;
        neg_q    <= dq[32];
        mag_q    <= dq[32] ? 33'(-dq) : 33'(dq);
        dur_q    <= duration_ms_i;
        drate_q  <= (duration_ms_i == 24'd0) ? 24'd1 : duration_ms_i;
        toff_q   <= start_time_ms_i;
        lastj_q  <= last_joint_i;
        n_q      <= seg_eff;
        k_q      <= '0;
        issued_q <= 1'b0;
        state_q  <= S_N3;
      end
    end else if (state_q == S_EMIT) begin
      if (out_free_i) begin
        if (k_q == n_q) begin
          state_q <= S_IDLE;
        end else begin
          k_q     <= k_q + 6'd1;
          state_q <= S_K3;
        end
      end
    end else if (!issued_q) begin
      issued_q <= 1'b1;
    end else if (rsp.done) begin
      issued_q <= 1'b0;
      case (state_q)
        S_N3: begin
          n3_q    <= rsp.res[17:0];
          state_q <= S_N4;
        end
        S_N4: begin
          n4_q    <= rsp.res[23:0];
          state_q <= S_N5;
        end
        S_N5: begin
          n5_q    <= rsp.res[29:0];
          state_q <= S_VDEN;
        end
        S_VDEN: begin
          vden_q  <= rsp.res << Rsh;
          state_q <= S_TAD;
        end
        S_TAD: begin
          tmp_q   <= rsp.res;
          state_q <= S_ADEN;
        end
        S_ADEN: begin
          aden_q  <= rsp.res << Rsh;
          state_q <= S_K3;
        end
        S_K3: begin
          tmp_q   <= rsp.res;
          state_q <= S_PQ;
        end
        S_PQ: begin
          tmp_q   <= rsp.res;
          state_q <= S_PA;
        end
        S_PA: begin
          tmp_q   <= rsp.res;
          state_q <= S_PDIV;
        end
        S_PDIV: begin
          pos_q   <= neg_q ? start_q - rsp.res[31:0] : start_q + rsp.res[31:0];
          state_q <= S_KK2;
        end
        S_KK2: begin
          tmp_q   <= rsp.res;
          state_q <= S_V2;
        end
        S_V2: begin
          tmp_q   <= rsp.res;
          state_q <= S_V3;
        end
        S_V3: begin
          tmp_q   <= rsp.res;
          state_q <= S_VDIV;
        end
        S_VDIV: begin
          vel_q   <= sat_signed(neg_q, rsp.ovf, rsp.res[QuoBits-1:0]);
          state_q <= S_A1;
        end
        S_A1: begin
          tmp_q   <= rsp.res;
          state_q <= S_A2;
        end
        S_A2: begin
          tmp_q   <= rsp.res;
          state_q <= S_A3;
        end
        S_A3: begin
          tmp_q   <= rsp.res;
          state_q <= S_ADIV;
        end
        S_ADIV: begin
          accel_q <= sat_signed(neg_q ^ n2k_neg, rsp.ovf, rsp.res[QuoBits-1:0]);
          state_q <= S_TM;
        end
        S_TM: begin
          tmp_q   <= rsp.res;
          state_q <= S_TDIV;
        end
        S_TDIV: begin
          time_q  <= {1'b0, toff_q} + rsp.res[31:0];
          state_q <= S_EMIT;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign idle_o = (state_q == S_IDLE);

  always_comb begin
    point_o.valid        = (state_q == S_EMIT);
    point_o.position     = pos_q;
    point_o.velocity     = vel_q;
    point_o.acceleration = accel_q;
    point_o.time_ms      = time_q;
    point_o.number       = k_q;
    point_o.last_point   = (k_q == n_q);
    point_o.end_of_plan  = (k_q == n_q) && lastj_q;
  end

endmodule

`default_nettype wire

>>> sv/quintic_trajectory_generator.sv
// Each joint first runs its setup steps, then computes its points one after another
// (the multiplications plus four divisions per point on the one shared unit).
// A new joint transaction is taken only once the last point of the previous one has left the core.
// A finished point waits in the output register while the next one is computed.
// Reset (rst_ni low, asynchronous) empties the block; segment_count returns to 20.
// Top level: configuration register, input handshake and output register.
// Depends on qtg_pkg and qtg_core.
`default_nettype none

module quintic_trajectory_generator import qtg_pkg::*; #(
  parameter int unsigned MAX_SEGMENTS       = DefMaxSegments,
  parameter int unsigned POSITION_FRAC_BITS = DefPosFracBits
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire  [5:0]  cfg_wdata_i,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [31:0] start_position_i,
  input  wire  [31:0] end_position_i,
  input  wire  [23:0] duration_ms_i,
  input  wire  [30:0] start_time_ms_i,
  input  wire         last_joint_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [31:0] point_position_o,
  output logic [31:0] point_velocity_o,
  output logic [31:0] point_acceleration_o,
  output logic [31:0] point_time_ms_o,
  output logic [5:0]  point_number_o,
  output logic        last_point_o,
  output logic        end_of_plan_o
);

  logic [5:0] seg_q;
  logic       idle;
  logic       out_free;
  point_t     point;
  point_t     out_q;

  // Segment count register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q <= SegResetValue;
    end else if (cfg_we_i) begin
      seg_q <= cfg_wdata_i;
    end
  end

  assign in_stall_o = !idle;
  assign out_free   = !out_q.valid || !out_stall_i;

  qtg_core #(
    .MAX_SEGMENTS       (MAX_SEGMENTS),
    .POSITION_FRAC_BITS (POSITION_FRAC_BITS)
  ) u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .seg_i            (seg_q),
    .item_i           (in_valid_i && idle),
    .start_position_i (start_position_i),
    .end_position_i   (end_position_i),
    .duration_ms_i    (duration_ms_i),
    .start_time_ms_i  (start_time_ms_i),
    .last_joint_i     (last_joint_i),
    .out_free_i       (out_free),
    .idle_o           (idle),
    .point_o          (point)
  );

  // Output register; refills in the cycle its transaction completes if the core holds a finished point.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q <= '0;
    end else if (out_free) begin
      if (point.valid) begin
        out_q <= point;
      end else begin
        out_q.valid <= 1'b0;
      end
    end
  end

  assign out_valid_o          = out_q.valid;
  assign point_position_o     = out_q.position;
  assign point_velocity_o     = out_q.velocity;
  assign point_acceleration_o = out_q.acceleration;
  assign point_time_ms_o      = out_q.time_ms;
  assign point_number_o       = out_q.number;
  assign last_point_o         = out_q.last_point;
  assign end_of_plan_o        = out_q.end_of_plan;

endmodule

`default_nettype wire

>>> sv/qtg_checker.sv
// Port-level checks for the quintic trajectory generator, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module qtg_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_valid_i,
  input wire        in_stall_o,
  input wire        out_valid_o,
  input wire        out_stall_i,
  input wire [31:0] point_position_o,
  input wire [5:0]  point_number_o,
  input wire        last_point_o,
  input wire        end_of_plan_o
);

  // A stalled point holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(point_position_o)
      && $stable(point_number_o))
    else $error("stalled output transaction changed");

  // The end of the plan is always the last point of a joint.
  a_eop_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_plan_o |-> last_point_o)
    else $error("end_of_plan without last_point");

  // While an earlier point of a joint is shown, the joint is still in work.
  a_busy_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_point_o |-> in_stall_o)
    else $error("input accepted before the joint finished");

  // An accepted joint occupies the block.
  a_busy_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("block idle right after an input transaction");

endmodule

bind quintic_trajectory_generator qtg_checker u_qtg_checker (.*);

`default_nettype wire

>>> test/tb_quintic_trajectory_generator.sv
// Self-checking testbench for quintic_trajectory_generator: directed table, then random joints.
// Predicts every trajectory point in SystemVerilog; depends on qtg_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_quintic_trajectory_generator;
  import qtg_pkg::*;

  localparam int unsigned WatchLimit = 30000;
  localparam int unsigned TailCycles = 600;

  typedef struct {
    logic [31:0] position;
    logic [31:0] velocity;
    logic [31:0] acceleration;
    logic [31:0] time_ms;
    logic [5:0]  number;
    logic        last_point;
    logic        end_of_plan;
  } traj_point_t;

  // One directed row: segment setting, joint fields, and whether the end points are typed in.
  typedef struct {
    logic [5:0]  seg;
    logic [31:0] start_pos;
    logic [31:0] end_pos;
    logic [23:0] dur;
    logic [30:0] toff;
    logic        lastj;
    logic        typed;
  } joint_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [5:0]  cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] start_position_i = '0;
  logic [31:0] end_position_i = '0;
  logic [23:0] duration_ms_i = '0;
  logic [30:0] start_time_ms_i = '0;
  logic        last_joint_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] point_position_o;
  logic [31:0] point_velocity_o;
  logic [31:0] point_acceleration_o;
  logic [31:0] point_time_ms_o;
  logic [5:0]  point_number_o;
  logic        last_point_o;
  logic        end_of_plan_o;

  traj_point_t pending_points[$];
  logic [5:0]  seg_setting = SegResetValue;
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;
  bit          failed = 1'b0;

  quintic_trajectory_generator dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .start_position_i     (start_position_i),
    .end_position_i       (end_position_i),
    .duration_ms_i        (duration_ms_i),
    .start_time_ms_i      (start_time_ms_i),
    .last_joint_i         (last_joint_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .point_position_o     (point_position_o),
    .point_velocity_o     (point_velocity_o),
    .point_acceleration_o (point_acceleration_o),
    .point_time_ms_o      (point_time_ms_o),
    .point_number_o       (point_number_o),
    .last_point_o         (last_point_o),
    .end_of_plan_o        (end_of_plan_o)
  );

  always #5 clk_i = ~clk_i;

  // Round num/den to nearest with ties away from zero, apply the sign, saturate to 32 bits.
  function automatic logic [31:0] rate_round(input logic neg, input logic [127:0] num,
                                             input logic [127:0] den);
    logic [127:0] q;
    q = (2 * num + den) / (2 * den);
    if (neg) return (q > 128'h8000_0000) ? SatNeg : (32'd0 - q[31:0]);
    return (q > 128'h7FFF_FFFF) ? SatPos : q[31:0];
  endfunction

  // Work out every point of one joint's move and queue them in order.
  function automatic void predict_joint(input logic [31:0] sp, input logic [31:0] ep,
                                        input logic [23:0] dur, input logic [30:0] toff,
                                        input logic lastj);
    longint       s, dq, nk, n2k, apoly, pqs;
    logic [127:0] mag, n, drate, n5, vden, aden, pmag, vpoly, amag;
    logic [63:0]  pos, tm;
    traj_point_t  pt;
    s = longint'(signed'(sp));
    dq = longint'(signed'(ep)) - s;
    mag = dq < 0 ? 128'(-dq) : 128'(dq);
    n = (seg_setting == 0) ? 128'd1 : 128'(seg_setting);
    drate = (dur == 0) ? 128'd1 : 128'(dur);
    n5 = n * n * n * n * n;
    vden = (n * n * n * n * drate) << (DefPosFracBits - 16);
    aden = (n * n * n * drate * drate) << (DefPosFracBits - 16);
    for (int k = 0; k <= int'(n); k++) begin
      nk = longint'(n) - k;
      n2k = longint'(n) - 2 * k;
      pqs = longint'(k) * k * k * (10 * longint'(n) * longint'(n) - 15 * longint'(k) *
            longint'(n) + 6 * longint'(k) * k);
      pmag = (mag * 128'(pqs) * 2 + n5) / (2 * n5);
      pos = dq < 0 ? 64'(s) - pmag[63:0] : 64'(s) + pmag[63:0];
      vpoly = 128'(30 * longint'(k) * k * nk * nk);
      apoly = 60 * longint'(k) * nk * n2k;
      amag = apoly < 0 ? 128'(-apoly) : 128'(apoly);
      tm = 64'(toff) + (64'(k) * 64'(dur)) / 64'(n);
      pt.position = pos[31:0];
      pt.velocity = rate_round(dq < 0, mag * vpoly * 1000, vden);
      pt.acceleration = rate_round((dq < 0) != (apoly < 0), mag * amag * 1000000, aden);
      pt.time_ms = tm[31:0];
      pt.number = 6'(k);
      pt.last_point = (k == int'(n));
      pt.end_of_plan = (k == int'(n)) && lastj;
      pending_points.insert(pending_points.size(), pt);
    end
  endfunction

  // Present one joint transaction, honoring burst gaps, and queue its points on acceptance.
  task automatic send_joint(input logic [31:0] sp, input logic [31:0] ep, input logic [23:0] dur,
                            input logic [30:0] toff, input logic lastj);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
      burst_left = $urandom_range(1, 6);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    start_position_i <= sp;
    end_position_i <= ep;
    duration_ms_i <= dur;
    start_time_ms_i <= toff;
    last_joint_i <= lastj;
    do @(posedge clk_i); while (in_stall_o);
    predict_joint(sp, ep, dur, toff, lastj);
    @(negedge clk_i);
  endtask

  // Let every queued point drain, then write the segment count while the block is idle.
  task automatic set_segments(input logic [5:0] value);
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_points.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    seg_setting = value;
  endtask

  // Compare each accepted point with the oldest prediction.
  always @(posedge clk_i) begin
    traj_point_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_points.size() == 0) begin
        $display("%0t: unexpected point, number %0d", $time, point_number_o);
        failed = 1'b1;
      end else begin
        want = pending_points.pop_front();
        if (point_position_o !== want.position) begin
          $display("%0t: position expected %h actual %h", $time, want.position,
                   point_position_o);
          failed = 1'b1;
        end
        if (point_velocity_o !== want.velocity) begin
          $display("%0t: velocity expected %h actual %h", $time, want.velocity,
                   point_velocity_o);
          failed = 1'b1;
        end
        if (point_acceleration_o !== want.acceleration) begin
          $display("%0t: acceleration expected %h actual %h", $time, want.acceleration,
                   point_acceleration_o);
          failed = 1'b1;
        end
        if (point_time_ms_o !== want.time_ms) begin
          $display("%0t: time expected %0d actual %0d", $time, want.time_ms, point_time_ms_o);
          failed = 1'b1;
        end
        if (point_number_o !== want.number) begin
          $display("%0t: number expected %0d actual %0d", $time, want.number, point_number_o);
          failed = 1'b1;
        end
        if (last_point_o !== want.last_point) begin
          $display("%0t: last_point expected %b actual %b", $time, want.last_point,
                   last_point_o);
          failed = 1'b1;
        end
        if (end_of_plan_o !== want.end_of_plan) begin
          $display("%0t: end_of_plan expected %b actual %b", $time, want.end_of_plan,
                   end_of_plan_o);
          failed = 1'b1;
        end
      end
    end
  end

  // Receiver back-pressure: stretches of random stall density, some of them quiet.
  always @(negedge clk_i) begin
    int unsigned mode_left;
    int unsigned density;
    if (mode_left == 0) begin
      mode_left = $urandom_range(50, 600);
      density = $urandom_range(0, 3);
    end
    mode_left--;
    out_stall_i <= (density != 0) && ($urandom_range(0, 3) < density);
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || !rst_ni) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
        $display("tb_quintic_trajectory_generator failed");
        $finish;
      end
    end
  end

  initial begin
    joint_row_t rows[$];
    traj_point_t first_pt, last_pt;
    int unsigned sel, lastq, npts;
    logic [31:0] sp, ep;
    logic [23:0] dur;

    // Directed table: reset segment count, then zero segments, then the maximum, then one segment.
    rows = '{
      '{6'd20, 32'h0000_0000, 32'h0100_0000, 24'd1000, 31'd0, 1'b0, 1'b1},
      '{6'd20, 32'h0100_0000, 32'h0000_0000, 24'd500, 31'd100, 1'b1, 1'b1},
      '{6'd20, 32'h8000_0000, 32'h7FFF_FFFF, 24'd1, 31'h7FFF_FFFF, 1'b0, 1'b1},
      '{6'd20, 32'h7FFF_FFFF, 32'h8000_0000, 24'd1, 31'd0, 1'b1, 1'b1},
      '{6'd20, 32'h1234_5678, 32'h1234_5678, 24'd250, 31'd7, 1'b0, 1'b1},
      '{6'd20, 32'h0000_0000, 32'h0200_0000, 24'd0, 31'd55, 1'b1, 1'b0},
      '{6'd20, 32'hFF00_0000, 32'h0300_0000, 24'hFF_FFFF, 31'd0, 1'b0, 1'b1},
      '{6'd20, 32'h0400_0000, 32'hFC00_0000, 24'd3, 31'd1, 1'b1, 1'b0},
      '{6'd20, 32'h0000_0001, 32'hFFFF_FFFF, 24'd7, 31'd2, 1'b0, 1'b0},
      '{6'd0, 32'h0000_0000, 32'h0100_0000, 24'd1000, 31'd10, 1'b1, 1'b1},
      '{6'd0, 32'h8000_0000, 32'h7FFF_FFFF, 24'd0, 31'h7FFF_FFFF, 1'b1, 1'b0},
      '{6'd0, 32'hDEAD_BEEF, 32'h1357_9BDF, 24'hFF_FFFF, 31'd3, 1'b0, 1'b1},
      '{6'd63, 32'h0000_0000, 32'h0100_0000, 24'd2000, 31'd0, 1'b1, 1'b1},
      '{6'd63, 32'h7FFF_FFFF, 32'h8000_0000, 24'd1, 31'd9, 1'b0, 1'b1},
      '{6'd1, 32'h0080_0000, 32'hFF80_0000, 24'd10, 31'd4, 1'b1, 1'b1},
      '{6'd1, 32'h0000_0000, 32'h7FFF_FFFF, 24'd1, 31'd0, 1'b0, 1'b1}
    };

    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].seg != seg_setting) set_segments(rows[i].seg);
      send_joint(rows[i].start_pos, rows[i].end_pos, rows[i].dur, rows[i].toff, rows[i].lastj);
      // Points of the previous joint may leave the queue meanwhile, so index from the tail.
      npts = (seg_setting == 6'd0) ? 2 : int'(seg_setting) + 1;
      lastq = pending_points.size() - npts;
      // At both ends of a move the speed and acceleration vanish and the position is exact.
      if (rows[i].typed) begin
        first_pt = pending_points[lastq];
        first_pt.position = rows[i].start_pos;
        first_pt.velocity = '0;
        first_pt.acceleration = '0;
        first_pt.time_ms = 32'(rows[i].toff);
        pending_points[lastq] = first_pt;
        last_pt = pending_points[pending_points.size() - 1];
        last_pt.position = rows[i].end_pos;
        last_pt.velocity = '0;
        last_pt.acceleration = '0;
        last_pt.time_ms = 32'(rows[i].toff) + 32'(rows[i].dur);
        pending_points[pending_points.size() - 1] = last_pt;
      end
    end

    // Random phases, mostly with few segments to keep the run short.
    for (int phase = 0; phase < 9; phase++) begin
      set_segments(phase == 0 ? 6'd0 : 6'($urandom_range(1, 8)));
      for (int j = 0; j < 20; j++) begin
        sel = $urandom_range(0, 9);
        sp = $urandom;
        ep = (sel < 5) ? sp + 32'($signed($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000)
                       : $urandom;
        if (sel == 0) dur = 24'd0;
        else if (sel < 3) dur = 24'($urandom);
        else dur = 24'($urandom_range(1, 5000));
        send_joint(sp, ep, dur, 31'($urandom), j == 19 || $urandom_range(0, 7) == 0);
      end
    end

    in_valid_i <= 1'b0;
    while (pending_points.size() != 0) @(negedge clk_i);
    repeat (TailCycles) @(negedge clk_i);
    if (!failed && pending_points.size() == 0) begin
      $display("tb_quintic_trajectory_generator passed");
    end else begin
      $display("tb_quintic_trajectory_generator failed");
    end
    $finish;
  end

endmodule
